[hdl/svg_pkg.sv]
// Shared types and constants of the sphere vertex generator.
// Used by the divider cell, the sine pipeline, the top level and the checker.
// Depends on nothing else.
package svg_pkg;

  // Clamps for the ring and sector counts.
  localparam logic [7:0] MAX_RINGS   = 8'd255;
  localparam logic [7:0] MAX_SECTORS = 8'd255;

  // Configuration register indexes.
  localparam logic [1:0] CFG_RING_COUNT   = 2'd0;
  localparam logic [1:0] CFG_SECTOR_COUNT = 2'd1;
  localparam logic [1:0] CFG_RADIUS       = 2'd2;

  // Divider chain: four lanes, one quotient bit per cell.
  localparam int DIV_LANES = 4;
  localparam int DIV_STEPS = 33;
  localparam int LANE_THETA = 0;
  localparam int LANE_PHI   = 1;
  localparam int LANE_U     = 2;
  localparam int LANE_V     = 3;

  typedef struct packed {
    logic [9:0]  rem;
    logic [32:0] work;
  } div_lane_t;

  typedef div_lane_t [DIV_LANES-1:0] div_lanes_t;
  typedef logic [DIV_LANES-1:0][9:0] divisors_t;

  // Sine pipeline: two setup stages, three stages per series term, one final.
  localparam int SINE_STEPS = 5;
  localparam int SINE_LAT   = 2 + 3 * SINE_STEPS + 1;

  localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

  localparam logic [63:0] RECIP_110 = (64'd1 << 38) / 64'd110;
  localparam logic [63:0] RECIP_72  = (64'd1 << 38) / 64'd72;
  localparam logic [63:0] RECIP_42  = (64'd1 << 37) / 64'd42;
  localparam logic [63:0] RECIP_20  = (64'd1 << 36) / 64'd20;
  localparam logic [63:0] RECIP_6   = (64'd1 << 34) / 64'd6;

  localparam logic [6:0] STEP_DIV [SINE_STEPS] = '{7'd110, 7'd72, 7'd42, 7'd20, 7'd6};
  localparam int STEP_SHIFT [SINE_STEPS] = '{38, 38, 37, 36, 34};
  localparam logic [31:0] STEP_RECIP [SINE_STEPS] = '{
    RECIP_110[31:0], RECIP_72[31:0], RECIP_42[31:0], RECIP_20[31:0], RECIP_6[31:0]
  };

  // Delay lines of the top level and total latency.
  localparam int SB_DEPTH = DIV_STEPS + SINE_LAT + 1;
  localparam int UV_DEPTH = SINE_LAT + 1;
  localparam int LATENCY  = SB_DEPTH + 1;

  typedef struct packed {
    logic        point_valid;
    logic        cell_valid;
    logic [15:0] corner;
    logic [15:0] below;
  } sideband_t;

  typedef struct packed {
    logic [30:0] x;
    logic [31:0] x2;
    logic        qneg;
  } sine_carry_t;

endpackage

[hdl/sphere_vertex_generator_top.sv]
// Top level of the sphere vertex generator: configuration, divider chain,
// four sine pipelines, normal and position stages.
// Depends on svg_pkg, svg_div_cell and svg_sine.
//
//   channel   ports                                   handshake
//   request   start, busy, in_ring_index, in_sector_  taken when start && !busy
//             index
//   result    out_valid, out_pos_*, out_norm_*, ...   one cycle strobe, no stall
//   config    cfg_we, cfg_index, cfg_wdata            taken when cfg_we
//
// Every request produces one result after passing the divider chain (one
// quotient bit per cell), the sine pipeline, the product register and the
// output register. A new request is taken every cycle, so busy stays low.
// Reset clears the pipeline valid bits and loads the register defaults;
// requests in flight are dropped. The receiver cannot stall, so nothing
// ever waits inside the block.
module sphere_vertex_generator_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  in_ring_index,
  input  logic [7:0]  in_sector_index,
  output logic        out_valid,
  output logic signed [23:0] out_pos_x,
  output logic signed [23:0] out_pos_y,
  output logic signed [23:0] out_pos_z,
  output logic signed [15:0] out_norm_x,
  output logic signed [15:0] out_norm_y,
  output logic signed [15:0] out_norm_z,
  output logic [16:0] out_tex_u,
  output logic [16:0] out_tex_v,
  output logic        out_point_valid,
  output logic        out_cell_valid,
  output logic [15:0] out_corner_index,
  output logic [15:0] out_below_index,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);
  import svg_pkg::*;

  // Configuration registers, read directly by every pipeline stage. The user must
  // change them only while no request is in flight; the block does not enforce it.
  logic [7:0]  ring_count_r;
  logic [7:0]  sector_count_r;
  logic [15:0] radius_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_count_r   <= 8'd16;
      sector_count_r <= 8'd32;
      radius_r       <= 16'd256;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RING_COUNT:   ring_count_r   <= cfg_wdata[7:0];
        CFG_SECTOR_COUNT: sector_count_r <= cfg_wdata[7:0];
        CFG_RADIUS:       radius_r       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic [7:0] rings;
  logic [7:0] sectors;
  assign rings   = (ring_count_r > MAX_RINGS) ? MAX_RINGS : ring_count_r;
  assign sectors = (sector_count_r > MAX_SECTORS) ? MAX_SECTORS : sector_count_r;

  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Request decode: validity flags and mesh indices are ready at once.
  sideband_t   sb_nxt;
  logic [16:0] corner_full;
  logic [16:0] row_len;

  always_comb begin
    row_len     = {8'd0, sectors} + 17'd1;
    corner_full = 17'(in_ring_index * row_len) + {9'd0, in_sector_index};
    sb_nxt.point_valid = (rings != 8'd0) && (sectors != 8'd0) &&
                         (in_ring_index <= rings) && (in_sector_index <= sectors);
    sb_nxt.cell_valid  = sb_nxt.point_valid && (in_ring_index < rings) &&
                         (in_sector_index < sectors);
    sb_nxt.corner = sb_nxt.cell_valid ? corner_full[15:0] : 16'd0;
    sb_nxt.below  = sb_nxt.cell_valid ? 16'(corner_full + row_len) : 16'd0;
  end

  // Dividends of the four divisions, split into the starting remainder and
  // the bits that the cells shift in. Angles are rounded to nearest.
  div_lanes_t lanes_first;
  divisors_t  divisors;

  always_comb begin
    lanes_first[LANE_THETA].rem  = {3'd0, in_ring_index[7:1]};
    lanes_first[LANE_THETA].work = {in_ring_index[0], 24'd0, rings};
    lanes_first[LANE_PHI].rem    = {3'd0, in_sector_index[7:1]};
    lanes_first[LANE_PHI].work   = {in_sector_index[0], 24'd0, 1'b0, sectors[7:1]};
    lanes_first[LANE_U].rem      = 10'd0;
    lanes_first[LANE_U].work     = {9'd0, in_sector_index, 9'd0, sectors[7:1]};
    lanes_first[LANE_V].rem      = 10'd0;
    lanes_first[LANE_V].work     = {9'd0, in_ring_index, 9'd0, rings[7:1]};
    divisors[LANE_THETA] = {1'b0, rings, 1'b0};
    divisors[LANE_PHI]   = {2'd0, sectors};
    divisors[LANE_U]     = {2'd0, sectors};
    divisors[LANE_V]     = {2'd0, rings};
  end

  // Divider chain: each cell hands its partial remainders to the next.
  div_lanes_t chain [DIV_STEPS+1];
  assign chain[0] = lanes_first;

  for (genvar c = 0; c < DIV_STEPS; c++) begin : g_cell
    svg_div_cell u_cell (
      .clk       (clk),
      .lanes_in  (chain[c]),
      .divisors  (divisors),
      .lanes_out (chain[c+1])
    );
  end

  logic [31:0] theta;
  logic [31:0] phi;
  assign theta = chain[DIV_STEPS][LANE_THETA].work[31:0];
  assign phi   = chain[DIV_STEPS][LANE_PHI].work[31:0];

  // Sines and cosines of both angles; a cosine is the sine a quarter on.
  logic [30:0] st_mag, ct_mag, sp_mag, cp_mag;
  logic        st_neg, ct_neg, sp_neg, cp_neg;

  svg_sine u_sin_theta (.clk(clk), .angle(theta), .mag(st_mag), .neg(st_neg));
  svg_sine u_cos_theta (.clk(clk), .angle(theta + 32'h4000_0000), .mag(ct_mag),
                        .neg(ct_neg));
  svg_sine u_sin_phi   (.clk(clk), .angle(phi), .mag(sp_mag), .neg(sp_neg));
  svg_sine u_cos_phi   (.clk(clk), .angle(phi + 32'h4000_0000), .mag(cp_mag),
                        .neg(cp_neg));

  // Texture coordinates wait alongside the sine pipelines.
  logic [16:0] u_r [UV_DEPTH];
  logic [16:0] v_r [UV_DEPTH];

  always_ff @(posedge clk) begin
    u_r[0] <= chain[DIV_STEPS][LANE_U].work[16:0];
    v_r[0] <= chain[DIV_STEPS][LANE_V].work[16:0];
    for (int k = 1; k < UV_DEPTH; k++) begin
      u_r[k] <= u_r[k-1];
      v_r[k] <= v_r[k-1];
    end
  end

  // Request sideband and valid bits follow the whole pipeline.
  sideband_t sb_r  [SB_DEPTH];
  logic      vld_r [SB_DEPTH];

  always_ff @(posedge clk) begin
    sb_r[0] <= sb_nxt;
    for (int k = 1; k < SB_DEPTH; k++) begin
      sb_r[k] <= sb_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < SB_DEPTH; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else begin
      vld_r[0] <= accept;
      for (int k = 1; k < SB_DEPTH; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
    end
  end

  // Normal magnitudes in Q30 with the sign kept apart.
  logic [61:0] prod_mx, prod_mz;
  logic [30:0] mx_nxt, mz_nxt;
  logic [30:0] mx_r, my_r, mz_r;
  logic        nx_r, ny_r, nz_r;

  always_comb begin
    prod_mx = {31'd0, cp_mag} * {31'd0, st_mag} + 62'(1 << 29);
    prod_mz = {31'd0, sp_mag} * {31'd0, st_mag} + 62'(1 << 29);
    mx_nxt  = prod_mx[60:30];
    mz_nxt  = prod_mz[60:30];
  end

  always_ff @(posedge clk) begin
    mx_r <= mx_nxt;
    my_r <= ct_mag;
    mz_r <= mz_nxt;
    nx_r <= (cp_neg != st_neg) && (mx_nxt != 31'd0);
    ny_r <= ct_neg;
    nz_r <= (sp_neg != st_neg) && (mz_nxt != 31'd0);
  end

  // Q1.15 normal component, rounded half up; plus one saturates.
  function automatic logic [15:0] norm_of(input logic [30:0] m, input logic n);
    logic [31:0] sum;
    logic [16:0] r;
    sum = {1'b0, m} + 32'd16384;
    r   = sum[31:15];
    if (n) begin
      return 16'(17'd0 - r);
    end
    return (r > 17'd32767) ? 16'd32767 : r[15:0];
  endfunction

  // Q9.15 position component: magnitude times the Q8.8 radius.
  function automatic logic [23:0] pos_of(input logic [30:0] m, input logic n,
                                         input logic [15:0] rad);
    logic [46:0] prod;
    logic [23:0] r;
    prod = {16'd0, m} * {31'd0, rad} + 47'(1 << 22);
    r    = prod[46:23];
    return n ? 24'(24'd0 - r) : r;
  endfunction

  // Output registers; an invalid point reads as all zero.
  sideband_t sb_last;
  logic      pv;
  assign sb_last = sb_r[SB_DEPTH-1];
  assign pv      = sb_last.point_valid;

  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vld_r[SB_DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    out_pos_x        <= pv ? pos_of(mx_r, nx_r, radius_r) : 24'd0;
    out_pos_y        <= pv ? pos_of(my_r, ny_r, radius_r) : 24'd0;
    out_pos_z        <= pv ? pos_of(mz_r, nz_r, radius_r) : 24'd0;
    out_norm_x       <= pv ? norm_of(mx_r, nx_r) : 16'd0;
    out_norm_y       <= pv ? norm_of(my_r, ny_r) : 16'd0;
    out_norm_z       <= pv ? norm_of(mz_r, nz_r) : 16'd0;
    out_tex_u        <= pv ? u_r[UV_DEPTH-1] : 17'd0;
    out_tex_v        <= pv ? v_r[UV_DEPTH-1] : 17'd0;
    out_point_valid  <= pv;
    out_cell_valid   <= sb_last.cell_valid;
    out_corner_index <= sb_last.corner;
    out_below_index  <= sb_last.below;
  end

  assign out_valid = out_valid_r;

endmodule

[hdl/svg_div_cell.sv]
// One cell of the divider chain: a restoring step on each of four lanes.
// Takes one dividend bit per lane and appends one quotient bit.
// Depends on svg_pkg.
module svg_div_cell (
  input  logic               clk,
  input  svg_pkg::div_lanes_t lanes_in,
  input  svg_pkg::divisors_t  divisors,
  output svg_pkg::div_lanes_t lanes_out
);
  import svg_pkg::*;

  div_lanes_t  lanes_r;
  div_lanes_t  lanes_nxt;
  logic [10:0] sh   [DIV_LANES];
  logic        ge   [DIV_LANES];

  always_comb begin
    for (int l = 0; l < DIV_LANES; l++) begin
      sh[l] = {lanes_in[l].rem, lanes_in[l].work[32]};
      ge[l] = (sh[l] >= {1'b0, divisors[l]});
      lanes_nxt[l].rem  = ge[l] ? 10'(sh[l] - {1'b0, divisors[l]}) : sh[l][9:0];
      lanes_nxt[l].work = {lanes_in[l].work[31:0], ge[l]};
    end
  end

  always_ff @(posedge clk) begin
    lanes_r <= lanes_nxt;
  end

  assign lanes_out = lanes_r;

endmodule

[hdl/svg_sine.sv]
// Pipelined sine of a full-turn angle: quadrant fold and Taylor series in Q30.
// Fully pipelined: one angle accepted every cycle.
// Depends on svg_pkg.
module svg_sine (
  input  logic        clk,
  input  logic [31:0] angle,
  output logic [30:0] mag,
  output logic        neg
);
  import svg_pkg::*;

  logic [30:0] f;
  logic [61:0] prod_x;
  logic [61:0] prod_x2;
  logic [30:0] x_r;
  logic        qneg_r;
  sine_carry_t c0_r;

  sine_carry_t ca_r [SINE_STEPS];
  sine_carry_t cb_r [SINE_STEPS];
  sine_carry_t cc_r [SINE_STEPS];
  logic [31:0] pa_r [SINE_STEPS];
  logic [31:0] pb_r [SINE_STEPS];
  logic [31:0] q0_r [SINE_STEPS];
  logic [30:0] t_r  [SINE_STEPS];

  logic [61:0] prod_fin;
  logic [30:0] mag_nxt;
  logic [30:0] mag_r;
  logic        neg_r;

  // Fold into the first quadrant; odd quadrants run backward.
  always_comb begin
    f = angle[30] ? 31'(Q30_ONE - {1'b0, angle[29:0]}) : {1'b0, angle[29:0]};
    prod_x  = {31'd0, f} * {31'd0, HALF_PI_Q30};
    prod_x2 = {31'd0, x_r} * {31'd0, x_r};
  end

  always_ff @(posedge clk) begin
    x_r     <= prod_x[60:30];
    qneg_r  <= angle[31];
    c0_r.x  <= x_r;
    c0_r.x2 <= prod_x2[61:30];
    c0_r.qneg <= qneg_r;
  end

  for (genvar k = 0; k < SINE_STEPS; k++) begin : g_step
    logic [30:0] t_in;
    sine_carry_t c_in;
    logic [62:0] prod_a;
    logic [63:0] prod_b;
    logic [31:0] back;
    logic [31:0] rest;
    logic [31:0] q;

    if (k == 0) begin : g_first
      assign t_in = Q30_ONE;
      assign c_in = c0_r;
    end else begin : g_next
      assign t_in = t_r[k-1];
      assign c_in = cc_r[k-1];
    end

    always_comb begin
      prod_a = {31'd0, c_in.x2} * {32'd0, t_in};
      prod_b = {32'd0, pa_r[k]} * {32'd0, STEP_RECIP[k]};
      back   = 32'(q0_r[k] * {25'd0, STEP_DIV[k]});
      rest   = pb_r[k] - back;
      q      = (rest >= {25'd0, STEP_DIV[k]}) ? q0_r[k] + 32'd1 : q0_r[k];
    end

    always_ff @(posedge clk) begin
      pa_r[k] <= prod_a[61:30];
      ca_r[k] <= c_in;
      q0_r[k] <= 32'(prod_b >> STEP_SHIFT[k]);
      pb_r[k] <= pa_r[k];
      cb_r[k] <= ca_r[k];
      t_r[k]  <= 31'(Q30_ONE - q[30:0]);
      cc_r[k] <= cb_r[k];
    end
  end

  always_comb begin
    prod_fin = {31'd0, cc_r[SINE_STEPS-1].x} * {31'd0, t_r[SINE_STEPS-1]};
    mag_nxt  = (prod_fin[60:30] > Q30_ONE) ? Q30_ONE : prod_fin[60:30];
  end

  always_ff @(posedge clk) begin
    mag_r <= mag_nxt;
    neg_r <= cc_r[SINE_STEPS-1].qneg && (mag_nxt != 31'd0);
  end

  assign mag = mag_r;
  assign neg = neg_r;

endmodule

[hdl/svg_checker.sv]
// Port-level checks of the sphere vertex generator, bound to the top level.
// Depends on svg_pkg and sphere_vertex_generator_top.
module svg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic signed [23:0] out_pos_x,
  input logic signed [23:0] out_pos_y,
  input logic signed [23:0] out_pos_z,
  input logic signed [15:0] out_norm_x,
  input logic signed [15:0] out_norm_y,
  input logic signed [15:0] out_norm_z,
  input logic [16:0] out_tex_u,
  input logic [16:0] out_tex_v,
  input logic        out_point_valid,
  input logic        out_cell_valid,
  input logic [15:0] out_corner_index,
  input logic [15:0] out_below_index
);
  import svg_pkg::*;

  // Every request comes back after the fixed latency.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_valid)
    else $error("request did not produce a result on time");

  // An invalid point carries no geometry.
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_point_valid) |-> (out_pos_x == 24'sd0 && out_pos_y == 24'sd0 &&
      out_pos_z == 24'sd0 && out_norm_x == 16'sd0 && out_norm_y == 16'sd0 &&
      out_norm_z == 16'sd0 && out_tex_u == 17'd0 && out_tex_v == 17'd0))
    else $error("invalid point with nonzero fields");

  // A cell exists only at a valid point.
  a_cell_in_point: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_cell_valid) |-> out_point_valid)
    else $error("cell flagged at an invalid point");

  // The vertex below lies one full row further on; checked as lying past the corner.
  a_below_after: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_cell_valid) |-> (out_below_index > out_corner_index))
    else $error("below index not past corner index");

endmodule

bind sphere_vertex_generator_top svg_checker u_svg_checker (.*);
